// ----- rtl/best_fit_block_allocator_macros.svh -----
// Assertion macros used by the checker file.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bfba_pkg.sv -----
`timescale 1ns / 1ps

package bfba_pkg;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_GRANTED = 2'd2,
        ST_NOFIT   = 2'd3
    } t_status;

    // Command beat
    typedef struct packed {
        logic        kind;
        logic [15:0] size;
    } t_cmd;

    // Result beat
    typedef struct packed {
        t_status     status;
        logic [3:0]  block_id;
    } t_rsp;

    // Control part of the search token that travels down the chain
    typedef struct packed {
        logic vld;
        logic found;
    } t_tok_ctl;

endpackage

// ----- rtl/bfba_cell.sv -----
`timescale 1ns / 1ps

module bfba_cell #(
    parameter int SIZE_BITS = 16,
    parameter int ID_BITS   = 4,
    parameter int IDX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // load port
    input  logic                   i_load_en,
    input  logic [ID_BITS-1:0]     i_load_id,
    input  logic [SIZE_BITS-1:0]   i_load_size,
    // grant port
    input  logic                   i_grant_en,
    input  logic [ID_BITS-1:0]     i_grant_id,
    // token from the previous cell
    input  bfba_pkg::t_tok_ctl     i_tok_ctl,
    input  logic [SIZE_BITS-1:0]   i_tok_req,
    input  logic [SIZE_BITS-1:0]   i_tok_size,
    input  logic [ID_BITS-1:0]     i_tok_id,
    // token to the next cell
    output bfba_pkg::t_tok_ctl     o_tok_ctl,
    output logic [SIZE_BITS-1:0]   o_tok_req,
    output logic [SIZE_BITS-1:0]   o_tok_size,
    output logic [ID_BITS-1:0]     o_tok_id
);
    import bfba_pkg::*;

    localparam logic [ID_BITS-1:0] MyId = ID_BITS'(IDX);

    logic                 r_loaded;
    logic                 r_used;
    logic [SIZE_BITS-1:0] r_size;
    t_tok_ctl             r_tok_ctl;
    logic [SIZE_BITS-1:0] r_tok_req;
    logic [SIZE_BITS-1:0] r_tok_size;
    logic [ID_BITS-1:0]   r_tok_id;

    logic fit;
    logic take;

    // Decide whether this block beats the best candidate so far
    always_comb begin
        fit  = r_loaded && !r_used && (r_size >= i_tok_req);
        take = fit && (!i_tok_ctl.found || (r_size < i_tok_size));
    end

    // Hold block state: written on load, marked used on grant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_used   <= 1'b0;
        end else if (i_load_en && (i_load_id == MyId)) begin
            r_loaded <= 1'b1;
            r_used   <= 1'b0;
        end else if (i_grant_en && (i_grant_id == MyId)) begin
            r_used   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en && (i_load_id == MyId)) begin
            r_size <= i_load_size;
        end
    end

    // Advance the token one cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_ctl <= '0;
        end else begin
            r_tok_ctl.vld   <= i_tok_ctl.vld;
            r_tok_ctl.found <= i_tok_ctl.found || fit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_req  <= i_tok_req;
        r_tok_size <= take ? r_size : i_tok_size;
        r_tok_id   <= take ? MyId : i_tok_id;
    end

    assign o_tok_ctl  = r_tok_ctl;
    assign o_tok_req  = r_tok_req;
    assign o_tok_size = r_tok_size;
    assign o_tok_id   = r_tok_id;

endmodule

// ----- rtl/best_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// Load: result strobe in the cycle after start; busy stays low, so one load per cycle
// while no allocate is in flight. Allocate: the search token walks one cell per cycle;
// busy stays high until the result shows, and no new command is taken while busy.
// Synchronous active-low reset empties the table and frees every block.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
module best_fit_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bfba_pkg::t_cmd  i_cmd,
    output logic            busy,
    output logic            o_done,
    output bfba_pkg::t_rsp  o_rsp
);
    import bfba_pkg::*;

    localparam int IdBits  = $clog2(NUM_BLOCKS);
    localparam int CntBits = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [CntBits-1:0]   r_count;
    logic                 r_done;
    t_rsp                 r_rsp;

    logic                 accept;
    logic                 do_load;
    logic                 full;
    logic [SIZE_BITS-1:0] cmd_size;
    logic                 grant_en;

    t_tok_ctl             tok_ctl  [0:NUM_BLOCKS];
    logic [SIZE_BITS-1:0] tok_req  [0:NUM_BLOCKS];
    logic [SIZE_BITS-1:0] tok_size [0:NUM_BLOCKS];
    logic [IdBits-1:0]    tok_id   [0:NUM_BLOCKS];

    assign accept   = start && !busy;
    assign cmd_size = SIZE_BITS'(i_cmd.size);
    assign full     = (r_count == CntBits'(NUM_BLOCKS));
    assign do_load  = accept && (i_cmd.kind == KIND_LOAD) && !full;
    assign grant_en = tok_ctl[NUM_BLOCKS].vld && tok_ctl[NUM_BLOCKS].found;

    // Inject a fresh token at the head of the chain
    always_comb begin
        tok_ctl[0].vld   = accept && (i_cmd.kind == KIND_ALLOC);
        tok_ctl[0].found = 1'b0;
        tok_req[0]       = cmd_size;
        tok_size[0]      = '0;
        tok_id[0]        = '0;
    end

    // Row of block cells
    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        bfba_cell #(
            .SIZE_BITS (SIZE_BITS),
            .ID_BITS   (IdBits),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load_en   (do_load),
            .i_load_id   (r_count[IdBits-1:0]),
            .i_load_size (cmd_size),
            .i_grant_en  (grant_en),
            .i_grant_id  (tok_id[NUM_BLOCKS]),
            .i_tok_ctl   (tok_ctl[g]),
            .i_tok_req   (tok_req[g]),
            .i_tok_size  (tok_size[g]),
            .i_tok_id    (tok_id[g]),
            .o_tok_ctl   (tok_ctl[g+1]),
            .o_tok_req   (tok_req[g+1]),
            .o_tok_size  (tok_size[g+1]),
            .o_tok_id    (tok_id[g+1])
        );
    end

    // Sequence: stay busy while a search token is in flight
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd.kind == KIND_ALLOC)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok_ctl[NUM_BLOCKS].vld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_load) begin
                r_count <= r_count + CntBits'(1);
            end
            r_done <= (accept && (i_cmd.kind == KIND_LOAD)) || tok_ctl[NUM_BLOCKS].vld;
        end
    end

    // Register the result beat
    always_ff @(posedge i_clk) begin
        priority if (tok_ctl[NUM_BLOCKS].vld) begin
            r_rsp.status   <= grant_en ? ST_GRANTED : ST_NOFIT;
            r_rsp.block_id <= grant_en ? 4'(tok_id[NUM_BLOCKS]) : 4'd0;
        end else if (accept && (i_cmd.kind == KIND_LOAD)) begin
            r_rsp.status   <= full ? ST_FULL : ST_LOADED;
            r_rsp.block_id <= full ? 4'd0 : 4'(r_count);
        end else begin
            r_rsp <= r_rsp;
        end
    end

    assign busy   = (r_state == S_SCAN);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- rtl/bfba_checker.sv -----
`timescale 1ns / 1ps
`include "best_fit_block_allocator_macros.svh"

module bfba_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bfba_pkg::t_cmd  i_cmd,
    input  logic            busy,
    input  logic            o_done,
    input  bfba_pkg::t_rsp  o_rsp
);
    import bfba_pkg::*;

    logic load_acc;
    logic alloc_acc;
    logic load_st;
    logic alloc_st;
    logic fail_st;
    logic busy_quiet;
    logic busy_fell;
    logic id_zero;
    logic r_busy_d;

    assign load_acc  = start && !busy && (i_cmd.kind == KIND_LOAD);
    assign alloc_acc = start && !busy && (i_cmd.kind == KIND_ALLOC);

    // Classify the result beat on the ports
    assign load_st    = o_done && ((o_rsp.status == ST_LOADED) || (o_rsp.status == ST_FULL));
    assign alloc_st   = o_done && ((o_rsp.status == ST_GRANTED) || (o_rsp.status == ST_NOFIT));
    assign fail_st    = o_done && ((o_rsp.status == ST_FULL) || (o_rsp.status == ST_NOFIT));
    assign busy_quiet = busy && !o_done;
    assign id_zero    = (o_rsp.block_id == 4'd0);

    // Hold last cycle's busy, counted only out of reset
    always_ff @(posedge i_clk) begin
        r_busy_d <= busy && i_rst_n;
    end

    assign busy_fell = r_busy_d && !busy;

    // A load answers in the next cycle with a load status
    `BFBA_ASSERT_NEXT(a_load_resp, i_clk, i_rst_n, load_acc, load_st, "load beat not answered")
    // An allocate holds the block busy
    `BFBA_ASSERT_NEXT(a_alloc_busy, i_clk, i_rst_n, alloc_acc, busy_quiet, "busy not raised")
    // Busy drops exactly when the allocate result shows
    `BFBA_ASSERT_NOW(a_busy_fall, i_clk, i_rst_n, busy_fell, alloc_st, "busy fell without a result")
    // Failed requests carry a zero id
    `BFBA_ASSERT_NOW(a_fail_id, i_clk, i_rst_n, fail_st, id_zero, "failed beat carries nonzero id")

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_cmd   (i_cmd),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
